// ----- src/gn2_pkg.sv -----
// gn2_pkg: shared types, queue sizes and gradient tables for the 2d gradient noise block
package gn2_pkg;

	// queue depths between front and back, and in front of the result port
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 16;

	// one classified sample handed from the front part to the back part
	typedef struct packed {
		logic [15:0]      fx;
		logic [15:0]      fy;
		logic [3:0][3:0]  g;
	} mid_entry_t;

	// gradient x component in q2.15, direction steps of 30 degrees
	function automatic logic signed [16:0] grad_x(input logic [3:0] g);
		logic signed [16:0] r;
		case (g)
			4'd0:    r = 17'sd32768;
			4'd1:    r = 17'sd28378;
			4'd2:    r = 17'sd16384;
			4'd3:    r = 17'sd0;
			4'd4:    r = -17'sd16384;
			4'd5:    r = -17'sd28378;
			4'd6:    r = -17'sd32768;
			4'd7:    r = -17'sd28378;
			4'd8:    r = -17'sd16384;
			4'd9:    r = 17'sd0;
			4'd10:   r = 17'sd16384;
			4'd11:   r = 17'sd28378;
			default: r = 17'sd0;
		endcase
		return r;
	endfunction

	// gradient y component in q2.15
	function automatic logic signed [16:0] grad_y(input logic [3:0] g);
		logic signed [16:0] r;
		case (g)
			4'd0:    r = 17'sd0;
			4'd1:    r = 17'sd16384;
			4'd2:    r = 17'sd28378;
			4'd3:    r = 17'sd32768;
			4'd4:    r = 17'sd28378;
			4'd5:    r = 17'sd16384;
			4'd6:    r = 17'sd0;
			4'd7:    r = -17'sd16384;
			4'd8:    r = -17'sd28378;
			4'd9:    r = -17'sd32768;
			4'd10:   r = -17'sd28378;
			4'd11:   r = -17'sd16384;
			default: r = 17'sd0;
		endcase
		return r;
	endfunction

	// hash mod 12 by reciprocal multiply, exact for all 8-bit hashes
	function automatic logic [3:0] mod12(input logic [7:0] h);
		logic [15:0] prod;
		logic [8:0]  q12;
		logic [7:0]  r8;
		prod = {8'd0, h} * 16'd171;
		q12  = {4'd0, prod[15:11]} * 9'd12;
		r8   = h - q12[7:0];
		return r8[3:0];
	endfunction

endpackage

// ----- src/gradient_noise_2d.sv -----
// gradient_noise_2d: top level of the 2d gradient noise evaluator
//
//  channel   handshake        payload
//  input     push / full      mode, entry_index, entry_value, x_coord, y_coord
//  result    pop / empty      noise_value
//
// One beat is taken per cycle unless full; a load beat writes the permutation table
// and gives no result. When nothing stalls, an evaluate beat passes through both table
// lookups, the sample queue, the arithmetic pipeline stages s1 to s8 and the write into
// the result queue before its result shows.
// Reset clears the queues and pipelines; the table holds nothing until loaded.
// full rises when the four-entry sample queue is spoken for; the back part stops
// issuing when the sixteen-entry result queue has no room for what is in flight.
module gradient_noise_2d #(
	parameter int LATTICE_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               mode,
	input  logic [7:0]         entry_index,
	input  logic [7:0]         entry_value,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] noise_value
);

	localparam int MW = $bits(gn2_pkg::mid_entry_t);

	logic                take;
	logic                mid_push;
	logic                mid_pop;
	logic                mid_empty;
	logic [2:0]          mid_count;
	gn2_pkg::mid_entry_t mid_in;
	gn2_pkg::mid_entry_t mid_out;
	logic [MW-1:0]       mid_dout;
	logic                out_push;
	logic                out_pop;
	logic [15:0]         out_din;
	logic [15:0]         out_dout;
	logic [4:0]          out_count;

	assign take    = push && !full;
	assign out_pop = pop && !empty;

	// front: table loads and corner hashing
	gn2_front #(.LATTICE_BITS(LATTICE_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.mode        (mode),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.mid_count   (mid_count),
		.full        (full),
		.mid_push    (mid_push),
		.mid_entry   (mid_in)
	);

	// sample queue between front and back
	gn2_fifo #(.WIDTH(MW), .DEPTH(gn2_pkg::MID_DEPTH)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.din    (mid_in),
		.pop    (mid_pop),
		.dout   (mid_dout),
		.empty  (mid_empty),
		.count  (mid_count)
	);
	assign mid_out = mid_dout;

	// back: arithmetic pipeline
	gn2_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_entry (mid_out),
		.mid_pop   (mid_pop),
		.out_count (out_count),
		.out_push  (out_push),
		.out_value (out_din)
	);

	// result queue
	gn2_fifo #(.WIDTH(16), .DEPTH(gn2_pkg::OUT_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    (out_din),
		.pop    (out_pop),
		.dout   (out_dout),
		.empty  (empty),
		.count  (out_count)
	);
	assign noise_value = $signed(out_dout);

`ifndef ASSERT_OFF
	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(mid_push && !mid_pop && mid_count == 3'(gn2_pkg::MID_DEPTH)))
		else $error("sample queue overflow");
	a_mid_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("sample queue read while empty");
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_push && !out_pop && out_count == 5'(gn2_pkg::OUT_DEPTH)))
		else $error("result queue overflow");
	a_full_when_queue_full: assert property (@(posedge clk) disable iff (!arst_n)
		(mid_count == 3'(gn2_pkg::MID_DEPTH)) |-> full)
		else $error("input taken with sample queue full");
`endif

endmodule

// ----- src/gn2_ram.sv -----
// gn2_ram: generic memory, one write port, two registered read ports (read old data)
module gn2_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

// ----- src/gn2_fifo.sv -----
// gn2_fifo: small register queue with occupancy count
module gn2_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           din,
	input  logic                       pop,
	output logic [WIDTH-1:0]           dout,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign dout  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

// ----- src/gn2_front.sv -----
// gn2_front: accepts beats, loads the permutation table and hashes the four cell corners
module gn2_front #(
	parameter int LATTICE_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic                mode,
	input  logic [7:0]          entry_index,
	input  logic [7:0]          entry_value,
	input  logic signed [31:0]  x_coord,
	input  logic signed [31:0]  y_coord,
	input  logic [2:0]          mid_count,
	output logic                full,
	output logic                mid_push,
	output gn2_pkg::mid_entry_t mid_entry
);

	localparam int LB = LATTICE_BITS;
	localparam int TD = 1 << LATTICE_BITS;

	logic [LB+7:0] widx_ext;
	logic [LB-1:0] waddr;
	logic          we;
	logic [LB-1:0] cx;
	logic [LB-1:0] cx1;
	logic [7:0]    first0;
	logic [7:0]    first1;

	logic          v_s1;
	logic [LB-1:0] cy_s1;
	logic [LB-1:0] cy1_s1;
	logic [15:0]   fx_s1;
	logic [15:0]   fy_s1;

	logic [LB+7:0] f0_ext;
	logic [LB+7:0] f1_ext;
	logic [LB-1:0] addr_a;
	logic [LB-1:0] addr_b;
	logic [LB-1:0] addr_c;
	logic [LB-1:0] addr_d;
	logic [7:0]    hash_a;
	logic [7:0]    hash_b;
	logic [7:0]    hash_c;
	logic [7:0]    hash_d;

	logic          v_s2;
	logic [15:0]   fx_s2;
	logic [15:0]   fy_s2;
	logic [3:0]    pending;

	// load beats write every table copy at the same address
	assign widx_ext = {{LB{1'b0}}, entry_index};
	assign waddr    = widx_ext[LB-1:0];
	assign we       = take && !mode;
	assign cx       = x_coord[16+LB-1:16];
	assign cx1      = cx + 1'b1;

	// first level lookup of the two column entries
	gn2_ram #(.WIDTH(8), .DEPTH(TD)) u_ram_col (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (entry_value),
		.raddr0 (cx),
		.raddr1 (cx1),
		.rdata0 (first0),
		.rdata1 (first1)
	);

	// stage 1 payload
	always_ff @(posedge clk) begin
		cy_s1  <= y_coord[16+LB-1:16];
		cy1_s1 <= y_coord[16+LB-1:16] + 1'b1;
		fx_s1  <= x_coord[15:0];
		fy_s1  <= y_coord[15:0];
	end

	// corner addresses for the second level lookup
	assign f0_ext = {{LB{1'b0}}, first0};
	assign f1_ext = {{LB{1'b0}}, first1};
	assign addr_a = f0_ext[LB-1:0] + cy_s1;
	assign addr_c = f0_ext[LB-1:0] + cy1_s1;
	assign addr_b = f1_ext[LB-1:0] + cy_s1;
	assign addr_d = f1_ext[LB-1:0] + cy1_s1;

	gn2_ram #(.WIDTH(8), .DEPTH(TD)) u_ram_left (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (entry_value),
		.raddr0 (addr_a),
		.raddr1 (addr_c),
		.rdata0 (hash_a),
		.rdata1 (hash_c)
	);

	gn2_ram #(.WIDTH(8), .DEPTH(TD)) u_ram_right (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (entry_value),
		.raddr0 (addr_b),
		.raddr1 (addr_d),
		.rdata0 (hash_b),
		.rdata1 (hash_d)
	);

	// stage 2 payload
	always_ff @(posedge clk) begin
		fx_s2 <= fx_s1;
		fy_s2 <= fy_s1;
	end

	// evaluate beats in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take && mode;
			v_s2 <= v_s1;
		end
	end

	// hand the classified sample to the queue
	assign mid_push     = v_s2;
	assign mid_entry.fx = fx_s2;
	assign mid_entry.fy = fy_s2;
	assign mid_entry.g  = {gn2_pkg::mod12(hash_d), gn2_pkg::mod12(hash_c),
	                       gn2_pkg::mod12(hash_b), gn2_pkg::mod12(hash_a)};

	// stop taking beats once the queue cannot hold what is in flight
	assign pending = {1'b0, mid_count} + {3'd0, v_s1} + {3'd0, v_s2};
	assign full    = (pending >= 4'(gn2_pkg::MID_DEPTH));

endmodule

// ----- src/gn2_back.sv -----
// gn2_back: fade curves, gradient dot products and the three blends
module gn2_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                mid_empty,
	input  gn2_pkg::mid_entry_t mid_entry,
	output logic                mid_pop,
	input  logic [4:0]          out_count,
	output logic                out_push,
	output logic [15:0]         out_value
);

	localparam int NS = 8;

	logic [NS:1]        stage_vld_q;
	logic [3:0]         inflight;
	logic [5:0]         room_need;

	logic signed [16:0] dx0;
	logic signed [16:0] dx1;
	logic signed [16:0] dy0;
	logic signed [16:0] dy1;
	logic signed [16:0] cdx [4];
	logic signed [16:0] cdy [4];

	logic [15:0]        f_s1   [2];
	logic [31:0]        f2_s1  [2];
	logic signed [33:0] prx_s1 [4];
	logic signed [33:0] pry_s1 [4];

	logic [47:0]        f3     [2];
	logic [34:0]        six    [2];
	logic [21:0]        pv     [2];
	logic [15:0]        c_s2   [2];
	logic [19:0]        p_s2   [2];
	logic signed [34:0] dot_s2 [4];

	logic [35:0]        fprod  [2];
	logic [16:0]        fade_s3 [2];
	logic signed [34:0] a_s3;
	logic signed [34:0] c_s3;
	logic signed [35:0] dtop_s3;
	logic signed [35:0] dbot_s3;

	logic signed [34:0] a_s4;
	logic signed [34:0] c_s4;
	logic signed [53:0] ptop_s4;
	logic signed [53:0] pbot_s4;
	logic [16:0]        v_s4;

	logic signed [35:0] top_s5;
	logic signed [35:0] bot_s5;
	logic [16:0]        v_s5;

	logic signed [36:0] d2_s6;
	logic signed [35:0] top_s6;
	logic [16:0]        v_s6;

	logic signed [54:0] p2_s7;
	logic signed [35:0] top_s7;

	logic signed [36:0] val_s8;
	logic signed [20:0] sh;

	// issue when a sample waits and the result queue has room for all in flight
	always_comb begin
		inflight = '0;
		for (int i = 1; i <= NS; i++) begin
			inflight = inflight + {3'd0, stage_vld_q[i]};
		end
	end
	assign room_need = {1'b0, out_count} + {2'd0, inflight};
	assign mid_pop   = !mid_empty && (room_need < 6'(gn2_pkg::OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			stage_vld_q <= {stage_vld_q[NS-1:1], mid_pop};
		end
	end

	// corner offsets: f, or f minus one in q1.16
	assign dx0 = $signed({1'b0, mid_entry.fx});
	assign dx1 = $signed({1'b1, mid_entry.fx});
	assign dy0 = $signed({1'b0, mid_entry.fy});
	assign dy1 = $signed({1'b1, mid_entry.fy});
	assign cdx[0] = dx0;
	assign cdy[0] = dy0;
	assign cdx[1] = dx1;
	assign cdy[1] = dy0;
	assign cdx[2] = dx0;
	assign cdy[2] = dy1;
	assign cdx[3] = dx1;
	assign cdy[3] = dy1;

	// s1: squares of the fractions and gradient products
	always_ff @(posedge clk) begin
		f_s1[0]  <= mid_entry.fx;
		f_s1[1]  <= mid_entry.fy;
		f2_s1[0] <= 32'(mid_entry.fx) * 32'(mid_entry.fx);
		f2_s1[1] <= 32'(mid_entry.fy) * 32'(mid_entry.fy);
		for (int i = 0; i < 4; i++) begin
			prx_s1[i] <= 34'(gn2_pkg::grad_x(mid_entry.g[i])) * 34'(cdx[i]);
			pry_s1[i] <= 34'(gn2_pkg::grad_y(mid_entry.g[i])) * 34'(cdy[i]);
		end
	end

	// fade polynomial pieces: cube and the quadratic factor
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			f3[k]  = 48'(f2_s1[k]) * 48'(f_s1[k]);
			six[k] = 35'(f2_s1[k]) * 35'd6;
			pv[k]  = 22'(six[k][34:16]) + 22'd655360 - 22'(f_s1[k]) * 22'd15;
		end
	end

	// s2: fade pieces and dot products
	always_ff @(posedge clk) begin
		for (int k = 0; k < 2; k++) begin
			c_s2[k] <= f3[k][47:32];
			p_s2[k] <= pv[k][19:0];
		end
		for (int i = 0; i < 4; i++) begin
			dot_s2[i] <= 35'(prx_s1[i]) + 35'(pry_s1[i]);
		end
	end

	// s3: fade values and the blend differences
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			fprod[k] = 36'(c_s2[k]) * 36'(p_s2[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 2; k++) begin
			fade_s3[k] <= fprod[k][32:16];
		end
		a_s3    <= dot_s2[0];
		c_s3    <= dot_s2[2];
		dtop_s3 <= 36'(dot_s2[1]) - 36'(dot_s2[0]);
		dbot_s3 <= 36'(dot_s2[3]) - 36'(dot_s2[2]);
	end

	// s4: scale the differences by the x fade
	always_ff @(posedge clk) begin
		a_s4    <= a_s3;
		c_s4    <= c_s3;
		v_s4    <= fade_s3[1];
		ptop_s4 <= 54'(dtop_s3) * 54'($signed({1'b0, fade_s3[0]}));
		pbot_s4 <= 54'(dbot_s3) * 54'($signed({1'b0, fade_s3[0]}));
	end

	// s5: top and bottom rows
	always_ff @(posedge clk) begin
		top_s5 <= 36'(a_s4) + 36'(ptop_s4 >>> 16);
		bot_s5 <= 36'(c_s4) + 36'(pbot_s4 >>> 16);
		v_s5   <= v_s4;
	end

	// s6: vertical difference
	always_ff @(posedge clk) begin
		d2_s6  <= 37'(bot_s5) - 37'(top_s5);
		top_s6 <= top_s5;
		v_s6   <= v_s5;
	end

	// s7: scale by the y fade
	always_ff @(posedge clk) begin
		p2_s7  <= 55'(d2_s6) * 55'($signed({1'b0, v_s6}));
		top_s7 <= top_s6;
	end

	// s8: final blend
	always_ff @(posedge clk) begin
		val_s8 <= 37'(top_s7) + 37'(p2_s7 >>> 16);
	end

	// back to q1.15 and saturate
	assign sh = 21'(val_s8 >>> 16);
	always_comb begin
		if (sh > 21'sd32767) begin
			out_value = 16'h7fff;
		end else if (sh < -21'sd32768) begin
			out_value = 16'h8000;
		end else begin
			out_value = sh[15:0];
		end
	end
	assign out_push = stage_vld_q[NS];

endmodule
